// ===== sv/tbid_pkg.sv =====
package tbid_pkg;

  // Widest index the decoder is built for.
  localparam int unsigned MaxIndexWidth = 48;

  // Result width: the block number of any index below 2^idx_w fits in idx_w/2+1 bits.
  function automatic int unsigned tbid_out_width(input int unsigned idx_w);
    tbid_out_width = (idx_w >> 1) + 1;
  endfunction

endpackage

// ===== sv/tbid_if.sv =====
interface tbid_idx_if import tbid_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [INDEX_WIDTH-1:0] flat_index;

  modport source (output valid, output flat_index, input ready);
  modport sink   (input valid, input flat_index, output ready);
endinterface

interface tbid_res_if import tbid_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 32
);
  localparam int unsigned OutWidth = tbid_out_width(INDEX_WIDTH);

  logic                valid;
  logic                ready;
  logic [OutWidth-1:0] block_number;
  logic [OutWidth-1:0] offset_in_block;

  modport source (output valid, output block_number, output offset_in_block, input ready);
  modport sink   (input valid, input block_number, input offset_in_block, output ready);
endinterface

// ===== sv/tbid_cell.sv =====
module tbid_cell import tbid_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 32,
  parameter int unsigned BIT         = 0
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic [tbid_out_width(INDEX_WIDTH)-1:0]   k_i,
  input  logic [INDEX_WIDTH-1:0]                   r_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output logic [tbid_out_width(INDEX_WIDTH)-1:0]   k_o,
  output logic [INDEX_WIDTH-1:0]                   r_o
);
  localparam int unsigned OutWidth = tbid_out_width(INDEX_WIDTH);
  localparam int unsigned DeltaW   = INDEX_WIDTH + 2;
  // T(2^b) = 2^b*(2^b+1)/2, the part of the step that does not depend on k.
  localparam logic [DeltaW-1:0] DeltaConst =
    ((DeltaW'(1) << (2 * BIT)) + (DeltaW'(1) << BIT)) >> 1;

  logic                   valid_q;
  logic [OutWidth-1:0]    k_q, k_d;
  logic [INDEX_WIDTH-1:0] r_q, r_d;
  logic [DeltaW-1:0]      delta;
  logic                   take;

  // Bits of k below BIT are still zero, so T(k + 2^b) - T(k) = k*2^b + T(2^b).
  always_comb begin
    delta = (DeltaW'(k_i) << BIT) + DeltaConst;
    take  = delta <= DeltaW'(r_i);
    if (take) begin
      r_d = r_i - delta[INDEX_WIDTH-1:0];
      k_d = k_i | (OutWidth'(1) << BIT);
    end else begin
      r_d = r_i;
      k_d = k_i;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      k_q <= k_d;
      r_q <= r_d;
    end
  end

  assign valid_o = valid_q;
  assign k_o     = k_q;
  assign r_o     = r_q;

endmodule

// ===== sv/triangular_block_index_decode_unit.sv =====
// Splits a flat element index into (block number, offset in block) for storage whose
// block k holds k+1 elements: the block number is the largest k with k*(k+1)/2 <= index,
// found exactly. A row of INDEX_WIDTH/2+1 cells settles one bit of k each, most
// significant first, with one compare-subtract per cell, and a new index transfers every
// cycle unless the row is stalled. Backpressure from the result side stalls the row;
// cells that hold no item still take input.
module triangular_block_index_decode_unit import tbid_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbid_idx_if.sink    idx_i,
  tbid_res_if.source  res_o
);
  localparam int unsigned OutWidth = tbid_out_width(INDEX_WIDTH);

  logic                   valid [OutWidth+1];
  logic                   ready [OutWidth+1];
  logic [OutWidth-1:0]    k     [OutWidth+1];
  logic [INDEX_WIDTH-1:0] r     [OutWidth+1];

  assign valid[0]    = idx_i.valid;
  assign idx_i.ready = ready[0];
  assign k[0]        = '0;
  assign r[0]        = idx_i.flat_index;

  for (genvar i = 0; i < OutWidth; i++) begin : g_cell
    tbid_cell #(
      .INDEX_WIDTH (INDEX_WIDTH),
      .BIT         (OutWidth - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .ready_o (ready[i]),
      .k_i     (k[i]),
      .r_i     (r[i]),
      .valid_o (valid[i+1]),
      .ready_i (ready[i+1]),
      .k_o     (k[i+1]),
      .r_o     (r[i+1])
    );
  end

  assign res_o.valid           = valid[OutWidth];
  assign ready[OutWidth]       = res_o.ready;
  assign res_o.block_number    = k[OutWidth];
  // Remainder never exceeds k, so the low bits hold all of it.
  assign res_o.offset_in_block = r[OutWidth][OutWidth-1:0];

endmodule
